FILE: rtl/core/md5_pkg.sv
// Shared types, constants and round tables of the MD5 hash engine.
`default_nettype none
package md5_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned BLK_WORDS  = 16;
  localparam int unsigned BLK_ADDR_W = 4;
  localparam int unsigned CNT_W      = 64;
  localparam int unsigned RND_W      = 6;
  localparam int unsigned IDX_W      = 2;

  localparam logic FUNC_ABSORB = 1'b0;
  localparam logic FUNC_FINISH = 1'b1;

  localparam logic [WORD_W-1:0] INIT_A = 32'h6745_2301;
  localparam logic [WORD_W-1:0] INIT_B = 32'hEFCD_AB89;
  localparam logic [WORD_W-1:0] INIT_C = 32'h98BA_DCFE;
  localparam logic [WORD_W-1:0] INIT_D = 32'h1032_5476;

  localparam logic [BYTE_W-1:0] PAD_MARK = 8'h80;

  localparam logic [BLK_ADDR_W-1:0] LEN_LO_WORD = 4'd14;
  localparam logic [BLK_ADDR_W-1:0] LEN_HI_WORD = 4'd15;

  localparam logic [WORD_W-1:0] K_TAB [64] = '{
    32'hD76AA478, 32'hE8C7B756, 32'h242070DB, 32'hC1BDCEEE,
    32'hF57C0FAF, 32'h4787C62A, 32'hA8304613, 32'hFD469501,
    32'h698098D8, 32'h8B44F7AF, 32'hFFFF5BB1, 32'h895CD7BE,
    32'h6B901122, 32'hFD987193, 32'hA679438E, 32'h49B40821,
    32'hF61E2562, 32'hC040B340, 32'h265E5A51, 32'hE9B6C7AA,
    32'hD62F105D, 32'h02441453, 32'hD8A1E681, 32'hE7D3FBC8,
    32'h21E1CDE6, 32'hC33707D6, 32'hF4D50D87, 32'h455A14ED,
    32'hA9E3E905, 32'hFCEFA3F8, 32'h676F02D9, 32'h8D2A4C8A,
    32'hFFFA3942, 32'h8771F681, 32'h6D9D6122, 32'hFDE5380C,
    32'hA4BEEA44, 32'h4BDECFA9, 32'hF6BB4B60, 32'hBEBFBC70,
    32'h289B7EC6, 32'hEAA127FA, 32'hD4EF3085, 32'h04881D05,
    32'hD9D4D039, 32'hE6DB99E5, 32'h1FA27CF8, 32'hC4AC5665,
    32'hF4292244, 32'h432AFF97, 32'hAB9423A7, 32'hFC93A039,
    32'h655B59C3, 32'h8F0CCC92, 32'hFFEFF47D, 32'h85845DD1,
    32'h6FA87E4F, 32'hFE2CE6E0, 32'hA3014314, 32'h4E0811A1,
    32'hF7537E82, 32'hBD3AF235, 32'h2AD7D2BB, 32'hEB86D391
  };

  localparam logic [4:0] ROT_TAB [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  typedef enum logic [1:0] {
    KIND_NORMAL,
    KIND_PAD_LEN,
    KIND_PAD_NOLEN,
    KIND_LEN_ONLY
  } kind_t;

  typedef struct packed {
    logic             func;
    logic [BYTE_W-1:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [WORD_W-1:0] digest_word;
    logic [IDX_W-1:0]  word_index;
    logic              last_word;
  } out_t;

  typedef struct packed {
    logic             absorb;
    logic             load;
    logic             round;
    logic [RND_W-1:0] rnd;
    logic [RND_W-1:0] fetch_rnd;
    logic             add;
    kind_t            kind;
    logic [IDX_W-1:0] idx;
    logic             clear;
  } cmd_t;

  typedef struct packed {
    logic blk_last;
    logic pad_two;
  } stat_t;

endpackage
`default_nettype wire

FILE: rtl/core/md5_hash_engine.sv
// Top level of the MD5 hash engine: byte-wide message intake, digest word output.
//
//  channel | direction | payload  | handshake
//  --------+-----------+----------+---------------------
//  in_     | input     | in_t     | in_valid / in_stall
//  out_    | output    | out_t    | out_valid / out_stall
//
// The 64th byte of a block is followed by a stall while the block is loaded, run
// through 64 rounds on the single round unit and added into the chaining words.
// A finish transaction runs one or two such blocks, then offers the four digest words,
// one per cycle while out_stall is low.
// Synchronous reset loads the initial chaining words and clears the byte counter.
// No input transaction is taken while a block is compressed or digest words are offered.
`default_nettype none
module md5_hash_engine (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire md5_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output md5_pkg::out_t      out_data
);
  import md5_pkg::*;

  cmd_t              cmd;
  stat_t             stat;
  logic [WORD_W-1:0] digest_word;

  md5_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_func   (in_data.func),
    .out_stall (out_stall),
    .stat      (stat),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  md5_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .data_byte   (in_data.data_byte),
    .stat        (stat),
    .digest_word (digest_word)
  );

  assign out_data.digest_word = digest_word;
  assign out_data.word_index  = cmd.idx;
  assign out_data.last_word   = (cmd.idx == IDX_W'(3));

endmodule
`default_nettype wire

FILE: rtl/core/md5_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module md5_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

FILE: rtl/core/md5_ctrl.sv
// Sequencing state machine of the MD5 hash engine.
`default_nettype none
module md5_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire logic           in_func,
  input  wire logic           out_stall,
  input  wire md5_pkg::stat_t stat,
  output logic                in_stall,
  output logic                out_valid,
  output md5_pkg::cmd_t       cmd
);
  import md5_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } state_t;

  localparam logic [RND_W-1:0] RND_LAST = RND_W'(63);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(3);

  state_t           state_r;
  logic [RND_W-1:0] rnd_r;
  logic [IDX_W-1:0] idx_r;
  kind_t            kind_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rnd_r   <= '0;
      idx_r   <= '0;
      kind_r  <= KIND_NORMAL;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            if (in_func == FUNC_FINISH) begin
              kind_r  <= stat.pad_two ? KIND_PAD_NOLEN : KIND_PAD_LEN;
              state_r <= ST_LOAD;
            end else if (stat.blk_last) begin
              kind_r  <= KIND_NORMAL;
              state_r <= ST_LOAD;
            end
          end
        end
        ST_LOAD: begin
          rnd_r   <= '0;
          state_r <= ST_ROUND;
        end
        ST_ROUND: begin
          rnd_r <= RND_W'(rnd_r + 1'b1);
          if (rnd_r == RND_LAST) begin
            state_r <= ST_ADD;
          end
        end
        ST_ADD: begin
          unique case (kind_r)
            KIND_NORMAL: begin
              state_r <= ST_IDLE;
            end
            KIND_PAD_NOLEN: begin
              kind_r  <= KIND_LEN_ONLY;
              state_r <= ST_LOAD;
            end
            default: begin
              idx_r   <= '0;
              state_r <= ST_EMIT;
            end
          endcase
        end
        ST_EMIT: begin
          if (!out_stall) begin
            idx_r <= IDX_W'(idx_r + 1'b1);
            if (idx_r == IDX_LAST) begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_EMIT);

  always_comb begin
    cmd           = '0;
    cmd.absorb    = (state_r == ST_IDLE) && in_valid && (in_func == FUNC_ABSORB);
    cmd.load      = (state_r == ST_LOAD);
    cmd.round     = (state_r == ST_ROUND);
    cmd.rnd       = rnd_r;
    cmd.fetch_rnd = (state_r == ST_ROUND) ? RND_W'(rnd_r + 1'b1) : '0;
    cmd.add       = (state_r == ST_ADD);
    cmd.kind      = kind_r;
    cmd.idx       = idx_r;
    cmd.clear     = (state_r == ST_EMIT) && !out_stall && (idx_r == IDX_LAST);
  end

endmodule
`default_nettype wire

FILE: rtl/core/md5_dp.sv
// Datapath of the MD5 hash engine: block buffer, byte counter, round logic, chaining words.
`default_nettype none
module md5_dp (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire md5_pkg::cmd_t                cmd,
  input  wire logic [md5_pkg::BYTE_W-1:0]   data_byte,
  output md5_pkg::stat_t                    stat,
  output logic      [md5_pkg::WORD_W-1:0]   digest_word
);
  import md5_pkg::*;

  function automatic logic [BLK_ADDR_W-1:0] msg_index(input logic [RND_W-1:0] r);
    logic [BLK_ADDR_W-1:0] i;
    logic [BLK_ADDR_W-1:0] sel;
    i = r[3:0];
    unique case (r[5:4])
      2'd0:    sel = i;
      2'd1:    sel = BLK_ADDR_W'(i * 4'd5 + 4'd1);
      2'd2:    sel = BLK_ADDR_W'(i * 4'd3 + 4'd5);
      default: sel = BLK_ADDR_W'(i * 4'd7);
    endcase
    return sel;
  endfunction

  logic [CNT_W-1:0]  cnt_r;
  logic [23:0]       asm_r;
  logic [WORD_W-1:0] cha_r, chb_r, chc_r, chd_r;
  logic [WORD_W-1:0] a_r, b_r, c_r, d_r;

  logic [5:0]            used;
  logic [1:0]            lane;
  logic [BLK_ADDR_W-1:0] part_word;
  logic                  ram_we;
  logic [WORD_W-1:0]     ram_wdata;
  logic [WORD_W-1:0]     ram_rdata;
  logic [BLK_ADDR_W-1:0] ram_raddr;

  logic [BLK_ADDR_W-1:0] g;
  logic [WORD_W-1:0]     mark_word;
  logic [WORD_W-1:0]     len_lo;
  logic [WORD_W-1:0]     len_hi;
  logic [WORD_W-1:0]     w;
  logic [WORD_W-1:0]     f;
  logic [WORD_W-1:0]     sum;
  logic [WORD_W-1:0]     rot_out;
  logic [4:0]            rot_amt;
  logic [WORD_W-1:0]     b_new;

  assign used      = cnt_r[5:0];
  assign lane      = used[1:0];
  assign part_word = used[5:2];

  assign stat.blk_last = (used == 6'd63);
  assign stat.pad_two  = (used[5:3] == 3'b111);

  assign ram_we    = cmd.absorb && (lane == 2'd3);
  assign ram_wdata = {data_byte, asm_r};
  assign ram_raddr = msg_index(cmd.fetch_rnd);

  md5_ram #(
    .WIDTH (WORD_W),
    .DEPTH (BLK_WORDS)
  ) u_blk_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (part_word),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    unique case (lane)
      2'd0:    mark_word = {24'h0, PAD_MARK};
      2'd1:    mark_word = {16'h0, PAD_MARK, asm_r[7:0]};
      2'd2:    mark_word = {8'h0, PAD_MARK, asm_r[15:0]};
      default: mark_word = {PAD_MARK, asm_r[23:0]};
    endcase
  end

  assign len_lo = {cnt_r[28:0], 3'b000};
  assign len_hi = cnt_r[60:29];

  assign g = msg_index(cmd.rnd);

  always_comb begin
    unique case (cmd.kind) inside
      KIND_NORMAL: begin
        w = ram_rdata;
      end
      KIND_PAD_LEN, KIND_PAD_NOLEN: begin
        if (g < part_word) begin
          w = ram_rdata;
        end else if (g == part_word) begin
          w = mark_word;
        end else if (cmd.kind == KIND_PAD_LEN && g == LEN_LO_WORD) begin
          w = len_lo;
        end else if (cmd.kind == KIND_PAD_LEN && g == LEN_HI_WORD) begin
          w = len_hi;
        end else begin
          w = '0;
        end
      end
      default: begin
        if (g == LEN_LO_WORD) begin
          w = len_lo;
        end else if (g == LEN_HI_WORD) begin
          w = len_hi;
        end else begin
          w = '0;
        end
      end
    endcase
  end

  always_comb begin
    unique case (cmd.rnd[5:4])
      2'd0:    f = d_r ^ (b_r & (c_r ^ d_r));
      2'd1:    f = c_r ^ (d_r & (b_r ^ c_r));
      2'd2:    f = b_r ^ c_r ^ d_r;
      default: f = c_r ^ (b_r | ~d_r);
    endcase
  end

  assign rot_amt = ROT_TAB[{cmd.rnd[5:4], cmd.rnd[1:0]}];
  assign sum     = a_r + f + K_TAB[cmd.rnd] + w;
  assign rot_out = (sum << rot_amt) | (sum >> (6'd32 - {1'b0, rot_amt}));
  assign b_new   = b_r + rot_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      cha_r <= INIT_A;
      chb_r <= INIT_B;
      chc_r <= INIT_C;
      chd_r <= INIT_D;
    end else if (cmd.clear) begin
      cnt_r <= '0;
      cha_r <= INIT_A;
      chb_r <= INIT_B;
      chc_r <= INIT_C;
      chd_r <= INIT_D;
    end else begin
      if (cmd.absorb) begin
        cnt_r <= CNT_W'(cnt_r + 1'b1);
      end
      if (cmd.add) begin
        cha_r <= cha_r + a_r;
        chb_r <= chb_r + b_r;
        chc_r <= chc_r + c_r;
        chd_r <= chd_r + d_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.absorb && lane != 2'd3) begin
      asm_r[lane*8 +: 8] <= data_byte;
    end
    if (cmd.load) begin
      a_r <= cha_r;
      b_r <= chb_r;
      c_r <= chc_r;
      d_r <= chd_r;
    end else if (cmd.round) begin
      a_r <= d_r;
      d_r <= c_r;
      c_r <= b_r;
      b_r <= b_new;
    end
  end

  always_comb begin
    unique case (cmd.idx)
      2'd0:    digest_word = cha_r;
      2'd1:    digest_word = chb_r;
      2'd2:    digest_word = chc_r;
      default: digest_word = chd_r;
    endcase
  end

endmodule
`default_nettype wire

FILE: sim/tb_md5_hash_engine.sv
// Self-checking testbench for md5_hash_engine: byte-stream stimulus, digest word scoreboard.
`timescale 1ns / 1ps
module tb_md5_hash_engine;
  import md5_pkg::*;

  localparam logic [31:0] CHAIN_IV [4] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476
  };
  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam int CALM_TAIL = 30;

  localparam logic [31:0] RND_ADD [64] = '{
    32'hD76AA478, 32'hE8C7B756, 32'h242070DB, 32'hC1BDCEEE,
    32'hF57C0FAF, 32'h4787C62A, 32'hA8304613, 32'hFD469501,
    32'h698098D8, 32'h8B44F7AF, 32'hFFFF5BB1, 32'h895CD7BE,
    32'h6B901122, 32'hFD987193, 32'hA679438E, 32'h49B40821,
    32'hF61E2562, 32'hC040B340, 32'h265E5A51, 32'hE9B6C7AA,
    32'hD62F105D, 32'h02441453, 32'hD8A1E681, 32'hE7D3FBC8,
    32'h21E1CDE6, 32'hC33707D6, 32'hF4D50D87, 32'h455A14ED,
    32'hA9E3E905, 32'hFCEFA3F8, 32'h676F02D9, 32'h8D2A4C8A,
    32'hFFFA3942, 32'h8771F681, 32'h6D9D6122, 32'hFDE5380C,
    32'hA4BEEA44, 32'h4BDECFA9, 32'hF6BB4B60, 32'hBEBFBC70,
    32'h289B7EC6, 32'hEAA127FA, 32'hD4EF3085, 32'h04881D05,
    32'hD9D4D039, 32'hE6DB99E5, 32'h1FA27CF8, 32'hC4AC5665,
    32'hF4292244, 32'h432AFF97, 32'hAB9423A7, 32'hFC93A039,
    32'h655B59C3, 32'h8F0CCC92, 32'hFFEFF47D, 32'h85845DD1,
    32'h6FA87E4F, 32'hFE2CE6E0, 32'hA3014314, 32'h4E0811A1,
    32'hF7537E82, 32'hBD3AF235, 32'h2AD7D2BB, 32'hEB86D391
  };

  localparam int RND_ROT [16] = '{
    7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
  };

  typedef struct packed {
    logic drain;
    in_t  pkt;
  } stim_t;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_stall;
  in_t   in_data = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  out_t  out_data;

  stim_t stim_q [$];
  out_t  digest_q [$];

  logic [31:0] chain [4];
  logic [7:0]  blk [64];
  logic [63:0] msg_bytes;

  bit in_fire = 1'b0;
  int send_gap = 0;
  int stall_left = 0;
  int errors = 0;
  int bytes_fed = 0;
  int digests_seen = 0;
  int spill_msgs = 0;
  int full_msgs = 0;

  md5_hash_engine i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function void md5_compress();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, f, t, sum;
    int g, q, sh;
    for (int j = 0; j < 16; j++)
      w[j] = {blk[4*j+3], blk[4*j+2], blk[4*j+1], blk[4*j]};
    a = chain[0];
    b = chain[1];
    c = chain[2];
    d = chain[3];
    for (int i = 0; i < 64; i++) begin
      q = i / 16;
      case (q)
        0: begin
          f = (b & c) | (~b & d);
          g = i;
        end
        1: begin
          f = (d & b) | (~d & c);
          g = (5 * i + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * i + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * i) % 16;
        end
      endcase
      sh = RND_ROT[q * 4 + i % 4];
      sum = a + f + RND_ADD[i] + w[g];
      t = d;
      d = c;
      c = b;
      b = b + ((sum << sh) | (sum >> (32 - sh)));
      a = t;
    end
    chain[0] = chain[0] + a;
    chain[1] = chain[1] + b;
    chain[2] = chain[2] + c;
    chain[3] = chain[3] + d;
  endfunction

  function void absorb_byte(input logic [7:0] value);
    blk[msg_bytes[5:0]] = value;
    msg_bytes = msg_bytes + 64'd1;
    bytes_fed++;
    if (msg_bytes[5:0] == 6'd0)
      md5_compress();
  endfunction

  function void finish_message();
    int used;
    logic [63:0] len_bits;
    out_t word;
    used = int'(msg_bytes[5:0]);
    if (used == 0 && msg_bytes != 64'd0)
      full_msgs++;
    blk[used] = PAD_BYTE;
    used++;
    if (used > 56) begin
      for (int j = used; j < 64; j++)
        blk[j] = 8'h00;
      md5_compress();
      spill_msgs++;
      used = 0;
    end
    for (int j = used; j < 56; j++)
      blk[j] = 8'h00;
    len_bits = msg_bytes << 3;
    for (int j = 0; j < 8; j++)
      blk[56 + j] = len_bits[8*j +: 8];
    md5_compress();
    for (int j = 0; j < 4; j++) begin
      word.digest_word = chain[j];
      word.word_index = j[1:0];
      word.last_word = (j == 3);
      digest_q.push_back(word);
    end
    for (int j = 0; j < 4; j++)
      chain[j] = CHAIN_IV[j];
    msg_bytes = 64'd0;
  endfunction

  task automatic queue_byte(input logic [7:0] value, input logic drain);
    stim_t s;
    s.drain = drain;
    s.pkt.func = FUNC_ABSORB;
    s.pkt.data_byte = value;
    stim_q.push_back(s);
  endtask

  task automatic queue_finish(input logic [7:0] junk, input logic drain);
    stim_t s;
    s.drain = drain;
    s.pkt.func = FUNC_FINISH;
    s.pkt.data_byte = junk;
    stim_q.push_back(s);
  endtask

  task automatic queue_message(input int len, input logic drain);
    for (int j = 0; j < len; j++)
      queue_byte(8'($urandom_range(0, 255)), drain && j == 0);
    queue_finish(8'($urandom_range(0, 255)), drain && len == 0);
  endtask

  // driver: present the next transaction once the previous one is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (stim_q.size() > 0 && !(stim_q[0].drain && digest_q.size() > 0)) begin
        in_data <= stim_q[0].pkt;
        in_valid <= 1'b1;
        void'(stim_q.pop_front());
        if (stim_q.size() > CALM_TAIL && $urandom_range(0, 9) == 0)
          send_gap <= $urandom_range(1, 19);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if (stim_q.size() > CALM_TAIL && $urandom_range(0, 11) == 0)
        stall_left <= $urandom_range(1, 19);
    end
  end

  // monitor: predict on input transactions, check output transactions
  always @(posedge clk) begin
    out_t want;
    in_fire = rst_n && in_valid && !in_stall;
    if (in_fire) begin
      if (in_data.func == FUNC_FINISH)
        finish_message();
      else
        absorb_byte(in_data.data_byte);
    end
    if (rst_n && out_valid && !out_stall) begin
      if (digest_q.size() == 0) begin
        $error("digest_word: none expected, got %h", out_data.digest_word);
        errors++;
      end else begin
        want = digest_q.pop_front();
        if (out_data.digest_word !== want.digest_word) begin
          $error("digest_word: expected %h, got %h", want.digest_word, out_data.digest_word);
          errors++;
        end
        if (out_data.word_index !== want.word_index) begin
          $error("word_index: expected %0d, got %0d", want.word_index, out_data.word_index);
          errors++;
        end
        if (out_data.last_word !== want.last_word) begin
          $error("last_word: expected %0d, got %0d", want.last_word, out_data.last_word);
          errors++;
        end
        if (want.last_word)
          digests_seen++;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    for (int j = 0; j < 4; j++)
      chain[j] = CHAIN_IV[j];
    for (int j = 0; j < 64; j++)
      blk[j] = 8'h00;
    msg_bytes = 64'd0;

    // empty message, with a non-zero byte on the finish
    queue_finish(8'hFF, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'h61, 1'b0);
    queue_finish(8'h00, 1'b0);
    queue_finish(8'h55, 1'b1);
    queue_byte(8'h5A, 1'b0);
    queue_finish(8'hAA, 1'b0);

    // block boundaries: pad fits, pad spills, marker in last slot, full block
    queue_message(55, 1'b0);
    queue_message(56, 1'b1);
    queue_message(63, 1'b0);
    queue_message(64, 1'b0);
    while (stim_q.size() < 270)
      queue_message($urandom_range(0, 12), $urandom_range(0, 5) == 0);

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    while (stim_q.size() != 0 || in_valid || digest_q.size() != 0)
      @(posedge clk);
    repeat (200) @(posedge clk);

    $display("Hashed %0d bytes into %0d digests.", bytes_fed, digests_seen);
    $display("Messages ending on a full block: %0d, padding spilled to a second block: %0d.",
             full_msgs, spill_msgs);
    if (errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
